// ===== src/ftc_pkg.sv =====
// shared types and constants for the frustum culling test
package ftc_pkg;

    localparam int PLANE_COUNT    = 6;
    localparam int NUM_PLANE_REGS = 6;
    localparam int PLANE_W        = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int COORD_W        = 16;
    localparam int RADIUS_W       = 15;
    localparam int FRAC_BITS      = 14;
    localparam int PROD_W         = 2 * COORD_W;
    localparam int DIST_W         = PROD_W + 3;

    typedef enum logic [1:0] {
        ACT_SPHERE = 2'd0,
        ACT_BOX    = 2'd1,
        ACT_POINT  = 2'd2,
        ACT_BAD    = 2'd3
    } t_action;

    typedef struct packed {
        t_action                     action;
        logic signed [COORD_W-1:0]   x_a;
        logic signed [COORD_W-1:0]   y_a;
        logic signed [COORD_W-1:0]   z_a;
        logic signed [COORD_W-1:0]   x_b;
        logic signed [COORD_W-1:0]   y_b;
        logic signed [COORD_W-1:0]   z_b;
        logic        [RADIUS_W-1:0]  radius;
        logic                        in_view;
    } t_item;

endpackage

// ===== src/ftc_cell.sv =====
// one plane of the chain: holds a plane, multiplies, then sums and tests
module ftc_cell
    import ftc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_wr_en,
    input  logic [PLANE_W-1:0] i_wr_data,
    input  logic               i_valid,
    input  t_item              i_item,
    output logic               o_ready,
    output logic               o_valid,
    output t_item              o_item,
    input  logic               i_ready
);

    logic [PLANE_W-1:0] r_plane;

    logic               r_valid1;
    t_item              r_item1;
    logic signed [PROD_W-1:0] r_prod1 [3];
    logic signed [PROD_W-1:0] r_prod2 [3];

    logic               r_valid2;
    t_item              r_item2;

    logic               s1_rdy;
    logic               s2_rdy;

    logic signed [COORD_W-1:0] nrm [3];
    logic signed [COORD_W-1:0] ca  [3];
    logic signed [COORD_W-1:0] cb  [3];
    logic signed [COORD_W-1:0] c1  [3];
    logic signed [COORD_W-1:0] c2  [3];
    logic signed [PROD_W-1:0]  n_prod1 [3];
    logic signed [PROD_W-1:0]  n_prod2 [3];

    logic [DIST_W-1:0] cst;
    logic [DIST_W-1:0] rad;
    logic [DIST_W-1:0] d1;
    logic [DIST_W-1:0] d2;
    logic [DIST_W-1:0] t1;
    logic              cull;
    t_item             n_item2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_wr_en) begin
            r_plane <= i_wr_data;
        end
    end

    assign s2_rdy  = !r_valid2 || i_ready;
    assign s1_rdy  = !r_valid1 || s2_rdy;
    assign o_ready = s1_rdy;

    // corner select: box takes min/max per normal sign, other modes use point a
    always_comb begin
        nrm[0] = r_plane[15:0];
        nrm[1] = r_plane[31:16];
        nrm[2] = r_plane[47:32];
        ca[0]  = i_item.x_a;
        ca[1]  = i_item.y_a;
        ca[2]  = i_item.z_a;
        cb[0]  = i_item.x_b;
        cb[1]  = i_item.y_b;
        cb[2]  = i_item.z_b;
        for (int k = 0; k < 3; k++) begin
            if (i_item.action == ACT_BOX) begin
                if (!nrm[k][COORD_W-1] && (nrm[k] != '0)) begin
                    c1[k] = ca[k];
                    c2[k] = cb[k];
                end else begin
                    c1[k] = cb[k];
                    c2[k] = ca[k];
                end
            end else begin
                c1[k] = ca[k];
                c2[k] = ca[k];
            end
            n_prod1[k] = nrm[k] * c1[k];
            n_prod2[k] = nrm[k] * c2[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
        end else if (s1_rdy) begin
            r_valid1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy && i_valid) begin
            r_item1 <= i_item;
            r_prod1 <= n_prod1;
            r_prod2 <= n_prod2;
        end
    end

    // distances in q.14, sign in the top bit
    always_comb begin
        cst = DIST_W'($signed(r_plane[63:48])) << FRAC_BITS;
        rad = DIST_W'({r_item1.radius, {FRAC_BITS{1'b0}}});
        d1  = DIST_W'(r_prod1[0]) + DIST_W'(r_prod1[1]) + DIST_W'(r_prod1[2]) + cst;
        d2  = DIST_W'(r_prod2[0]) + DIST_W'(r_prod2[1]) + DIST_W'(r_prod2[2]) + cst;
        t1  = (r_item1.action == ACT_SPHERE) ? d1 + rad : d1;
        if (r_item1.action == ACT_BOX) begin
            cull = t1[DIST_W-1] && d2[DIST_W-1];
        end else begin
            cull = t1[DIST_W-1];
        end
        n_item2         = r_item1;
        n_item2.in_view = r_item1.in_view && !cull;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid2 <= 1'b0;
        end else if (s2_rdy) begin
            r_valid2 <= r_valid1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_rdy && r_valid1) begin
            r_item2 <= n_item2;
        end
    end

    assign o_valid = r_valid2;
    assign o_item  = r_item2;

`ifndef ASSERT_OFF
    a_no_revive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_rdy && r_valid1) |=> (!r_item2.in_view || $past(r_item1.in_view)))
        else $error("cell turned a culled word back to inside");

    a_bad_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid2 && (r_item2.action == ACT_BAD)) |-> !r_item2.in_view)
        else $error("undefined action reported inside");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid2 && !i_ready) |=> (r_valid2 && $stable(r_item2)))
        else $error("stalled word in cell changed");
`endif

endmodule

// ===== src/frustum_culling_test.sv =====
// channel  | valid        | ready        | payload
// ---------+--------------+--------------+----------------------------------------
// in       | i_in_valid   | o_in_ready   | i_action, i_x_a..i_z_b, i_radius
// out      | o_out_valid  | i_out_ready  | o_inside_res
// cfg      | i_cfg_valid  | o_cfg_ready  | i_cfg_index, i_cfg_data
//
// one word per cycle sustained while i_out_ready stays high
// each cell multiplies in its first stage and sums and compares in its second
// the last cell's second stage is the output register; stalls back up stage by stage
// synchronous reset clears the planes to zero and empties the chain
module frustum_culling_test
    import ftc_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [PLANE_W-1:0]         i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [1:0]                 i_action,
    input  logic signed [COORD_W-1:0]  i_x_a,
    input  logic signed [COORD_W-1:0]  i_y_a,
    input  logic signed [COORD_W-1:0]  i_z_a,
    input  logic signed [COORD_W-1:0]  i_x_b,
    input  logic signed [COORD_W-1:0]  i_y_b,
    input  logic signed [COORD_W-1:0]  i_z_b,
    input  logic [RADIUS_W-1:0]        i_radius,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_inside_res
);

    logic  c_valid [PLANE_COUNT+1];
    logic  c_ready [PLANE_COUNT+1];
    t_item c_item  [PLANE_COUNT+1];
    t_item in_item;

    assign o_cfg_ready = 1'b1;

    always_comb begin
        in_item.action = t_action'(i_action);
        in_item.x_a    = i_x_a;
        in_item.y_a    = i_y_a;
        in_item.z_a    = i_z_a;
        in_item.x_b    = i_x_b;
        in_item.y_b    = i_y_b;
        in_item.z_b    = i_z_b;
        in_item.radius = i_radius;
        // undefined action starts out culled and stays so
        in_item.in_view = (t_action'(i_action) != ACT_BAD);
    end

    assign c_item[0]            = in_item;
    assign c_valid[0]           = i_in_valid;
    assign o_in_ready           = c_ready[0];
    assign c_ready[PLANE_COUNT] = i_out_ready;

    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
        logic wr_en;

        // planes past the register list never get written
        assign wr_en = i_cfg_valid && (g < NUM_PLANE_REGS)
                       && (i_cfg_index == CFG_IDX_W'(g));

        ftc_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (wr_en),
            .i_wr_data (i_cfg_data),
            .i_valid   (c_valid[g]),
            .i_item    (c_item[g]),
            .o_ready   (c_ready[g]),
            .o_valid   (c_valid[g+1]),
            .o_item    (c_item[g+1]),
            .i_ready   (c_ready[g+1])
        );
    end

    assign o_out_valid  = c_valid[PLANE_COUNT];
    assign o_inside_res = c_item[PLANE_COUNT].in_view;

`ifndef ASSERT_OFF
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready))
        else $error("input stalled without a blocked output");
`endif

endmodule

// ===== tb/frustum_culling_test_tb.sv =====
// self-checking testbench for the six-plane frustum culling test
`timescale 1ns / 1ps

module frustum_culling_test_tb
    import ftc_pkg::*;
();

    localparam int DRAIN_CYCLES  = 16;
    localparam int STALL_LIMIT   = 5000;
    localparam int HOLD_CYCLES   = 150;
    localparam int SPAN_NEAR     = 12000;
    localparam int MAX_REPORTS   = 20;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index = '0;
    logic [PLANE_W-1:0]        i_cfg_data = '0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [1:0]                i_action = '0;
    logic signed [COORD_W-1:0] i_x_a = '0;
    logic signed [COORD_W-1:0] i_y_a = '0;
    logic signed [COORD_W-1:0] i_z_a = '0;
    logic signed [COORD_W-1:0] i_x_b = '0;
    logic signed [COORD_W-1:0] i_y_b = '0;
    logic signed [COORD_W-1:0] i_z_b = '0;
    logic [RADIUS_W-1:0]       i_radius = '0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic                      o_inside_res;

    logic [PLANE_W-1:0] plane_model [PLANE_COUNT];
    logic               pending_inside_q [$];
    int                 send_idle_pct = 0;
    int                 recv_stall_pct = 0;
    int                 hold_left = 0;
    int                 err_count = 0;
    int                 items_sent = 0;
    int                 results_checked = 0;
    int                 plane_writes = 0;
    int                 quiet_cycles = 0;

    frustum_culling_test uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_action     (i_action),
        .i_x_a        (i_x_a),
        .i_y_a        (i_y_a),
        .i_z_a        (i_z_a),
        .i_x_b        (i_x_b),
        .i_y_b        (i_y_b),
        .i_z_b        (i_z_b),
        .i_radius     (i_radius),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_inside_res (o_inside_res)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // signed distance in Q.14 units, exact
    function automatic longint plane_dist(input logic [PLANE_W-1:0] p,
                                          input longint x, input longint y,
                                          input longint z);
        return longint'($signed(p[15:0])) * x + longint'($signed(p[31:16])) * y
             + longint'($signed(p[47:32])) * z
             + longint'($signed(p[63:48])) * longint'(1 << FRAC_BITS);
    endfunction

    function automatic logic predict_inside(input t_item it);
        longint             ax, ay, az, bx, by, bz, neg_r, d1, d2;
        logic [PLANE_W-1:0] p;
        logic               px, py, pz;
        logic               keep;
        ax = longint'($signed(it.x_a));
        ay = longint'($signed(it.y_a));
        az = longint'($signed(it.z_a));
        bx = longint'($signed(it.x_b));
        by = longint'($signed(it.y_b));
        bz = longint'($signed(it.z_b));
        neg_r = -(longint'(it.radius) * longint'(1 << FRAC_BITS));
        keep = 1'b1;
        if (it.action == ACT_BAD)
            return 1'b0;
        for (int i = 0; i < PLANE_COUNT; i++) begin
            p = plane_model[i];
            case (it.action)
                ACT_SPHERE: begin
                    if (plane_dist(p, ax, ay, az) < neg_r)
                        keep = 1'b0;
                end
                ACT_POINT: begin
                    if (plane_dist(p, ax, ay, az) < 0)
                        keep = 1'b0;
                end
                default: begin
                    // nearest and farthest corner along the normal
                    px = $signed(p[15:0]) > 0;
                    py = $signed(p[31:16]) > 0;
                    pz = $signed(p[47:32]) > 0;
                    d1 = plane_dist(p, px ? ax : bx, py ? ay : by, pz ? az : bz);
                    d2 = plane_dist(p, px ? bx : ax, py ? by : ay, pz ? bz : az);
                    if (d1 < 0 && d2 < 0)
                        keep = 1'b0;
                end
            endcase
        end
        return keep;
    endfunction

    function automatic logic [PLANE_W-1:0] pack_plane(input logic [15:0] nx,
                                                      input logic [15:0] ny,
                                                      input logic [15:0] nz,
                                                      input logic [15:0] c);
        return {c, nz, ny, nx};
    endfunction

    function automatic logic [15:0] rand_coord(input int span);
        if (span == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic t_item rand_item(input int span);
        t_item it;
        it = '0;
        it.action = ($urandom_range(0, 99) < 5) ? ACT_BAD : t_action'($urandom_range(0, 2));
        it.x_a = rand_coord(span);
        it.y_a = rand_coord(span);
        it.z_a = rand_coord(span);
        if (span == 0 || $urandom_range(0, 9) == 0) begin
            it.x_b = rand_coord(0);
            it.y_b = rand_coord(0);
            it.z_b = rand_coord(0);
            it.radius = RADIUS_W'($urandom);
        end else begin
            // mostly ordered boxes, some slightly reversed
            it.x_b = it.x_a + 16'($urandom_range(0, span / 2 + span / 8) - span / 8);
            it.y_b = it.y_a + 16'($urandom_range(0, span / 2 + span / 8) - span / 8);
            it.z_b = it.z_a + 16'($urandom_range(0, span / 2 + span / 8) - span / 8);
            it.radius = RADIUS_W'($urandom_range(0, span / 3));
        end
        return it;
    endfunction

    // roughly axis aligned box frustum with tilted normals
    function automatic logic [PLANE_W-1:0] rand_box_plane(input int k);
        logic [15:0] n [3];
        int          main_n;
        main_n = $urandom_range(8000, 16383);
        for (int a = 0; a < 3; a++)
            n[a] = 16'($urandom_range(0, 4000) - 2000);
        n[k / 2] = (k % 2) ? 16'(-main_n) : 16'(main_n);
        return pack_plane(n[0], n[1], n[2], 16'($urandom_range(3000, 12000)));
    endfunction

    task automatic send_item(input t_item it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= it.action;
        i_x_a      <= it.x_a;
        i_y_a      <= it.y_a;
        i_z_a      <= it.z_a;
        i_x_b      <= it.x_b;
        i_y_b      <= it.y_b;
        i_z_b      <= it.z_b;
        i_radius   <= it.radius;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pending_inside_q.push_back(predict_inside(it));
        items_sent++;
    endtask

    task automatic stop_input();
        i_in_valid <= 1'b0;
    endtask

    task automatic send_shape(input t_action act,
                              input int xa, input int ya, input int za,
                              input int xb, input int yb, input int zb,
                              input int r);
        t_item it;
        it = '0;
        it.action = act;
        it.x_a = 16'(xa);
        it.y_a = 16'(ya);
        it.z_a = 16'(za);
        it.x_b = 16'(xb);
        it.y_b = 16'(yb);
        it.z_b = 16'(zb);
        it.radius = RADIUS_W'(r);
        send_item(it);
    endtask

    task automatic wait_drain();
        while (pending_inside_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // leaves the valid high so that back-to-back writes need no second update
    task automatic write_plane(input logic [CFG_IDX_W-1:0] idx,
                               input logic [PLANE_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (idx < NUM_PLANE_REGS && idx < PLANE_COUNT)
            plane_model[idx] = val;
        plane_writes++;
    endtask

    task automatic load_planes(input logic [PLANE_W-1:0] set [PLANE_COUNT]);
        wait_drain();
        for (int i = 0; i < PLANE_COUNT; i++)
            write_plane(CFG_IDX_W'(i), set[i]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_zero_planes();
        send_shape(ACT_POINT, -32768, 32767, 0, 0, 0, 0, 0);
        send_shape(ACT_SPHERE, 32767, -32768, 32767, 0, 0, 0, 0);
        send_shape(ACT_BOX, 100, 100, 100, -100, -100, -100, 0);
        send_shape(ACT_BAD, 0, 0, 0, 0, 0, 0, 0);
        stop_input();
    endtask

    task automatic test_unit_cube();
        logic [PLANE_W-1:0] set [PLANE_COUNT];
        for (int i = 0; i < PLANE_COUNT; i++) begin
            set[i] = '0;
            set[i][16 * (i / 2) +: 16] = (i % 2) ? 16'hC000 : 16'h4000;
            set[i][63:48] = 16'd1000;
        end
        load_planes(set);
        send_shape(ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
        send_shape(ACT_POINT, 1001, 0, 0, 0, 0, 0, 0);
        send_shape(ACT_POINT, 1000, -1000, 1000, 0, 0, 0, 0);
        send_shape(ACT_POINT, -32768, 32767, -32768, 0, 0, 0, 0);
        send_shape(ACT_SPHERE, 1500, 0, 0, 0, 0, 0, 499);
        send_shape(ACT_SPHERE, 1500, 0, 0, 0, 0, 0, 500);
        send_shape(ACT_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767);
        send_shape(ACT_SPHERE, 32767, 32767, 32767, 0, 0, 0, 0);
        send_shape(ACT_BOX, -5000, -5000, -5000, 5000, 5000, 5000, 0);
        send_shape(ACT_BOX, 2000, 0, 0, 3000, 10, 10, 0);
        // reversed box: min above max on one axis
        send_shape(ACT_BOX, 3000, 0, 0, 2000, 10, 10, 0);
        send_shape(ACT_BOX, 0, 5000, 0, 10, -5000, 10, 0);
        send_shape(ACT_BAD, 0, 0, 0, 0, 0, 0, 32767);
        stop_input();
    endtask

    task automatic test_unused_index();
        wait_drain();
        write_plane(CFG_IDX_W'(NUM_PLANE_REGS), '1);
        write_plane(CFG_IDX_W'(NUM_PLANE_REGS + 1), '1);
        i_cfg_valid <= 1'b0;
        send_shape(ACT_POINT, 0, 0, 0, 0, 0, 0, 0);
        send_shape(ACT_POINT, 999, 999, -999, 0, 0, 0, 0);
        send_shape(ACT_BOX, -1, -1, -1, 1, 1, 1, 0);
        stop_input();
    endtask

    task automatic test_extreme_planes();
        logic [PLANE_W-1:0] set [PLANE_COUNT];
        set[0] = pack_plane(16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
        set[1] = pack_plane(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF);
        set[2] = pack_plane(16'h0000, 16'h0000, 16'h0000, 16'h7FFF);
        set[3] = pack_plane(16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
        set[4] = '0;
        set[5] = pack_plane(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000);
        load_planes(set);
        send_shape(ACT_POINT, -32768, -32768, -32768, 0, 0, 0, 0);
        send_shape(ACT_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767);
        send_shape(ACT_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0);
        for (int n = 0; n < 30; n++)
            send_item(rand_item(0));
        stop_input();
    endtask

    task automatic test_backpressure();
        wait_drain();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(negedge i_clk);
        hold_left = HOLD_CYCLES;
        @(posedge i_clk);
        for (int n = 0; n < 40; n++)
            send_item(rand_item(SPAN_NEAR));
        stop_input();
        // sender stays quiet until the block is empty
        wait_drain();
    endtask

    task automatic test_random_traffic();
        logic [PLANE_W-1:0] set [PLANE_COUNT];
        int                 send_pct [4] = '{0, 58, 0, 27};
        int                 recv_pct [4] = '{0, 0, 58, 27};
        for (int ph = 0; ph < 4; ph++) begin
            for (int i = 0; i < PLANE_COUNT; i++)
                set[i] = (ph == 2) ? {$urandom, $urandom} : rand_box_plane(i);
            load_planes(set);
            send_idle_pct = send_pct[ph];
            recv_stall_pct = recv_pct[ph];
            for (int n = 0; n < 110; n++)
                send_item(rand_item(($urandom_range(0, 4) == 0) ? 0 : SPAN_NEAR));
            stop_input();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // result side: random stalls, long hold on request, in-order compare
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_inside_q.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("%0t: unexpected word, inside_res %0b", $time, o_inside_res);
            end else begin
                if (o_inside_res !== pending_inside_q[0]) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("%0t: inside_res mismatch, expected %0b, got %0b",
                                 $time, pending_inside_q[0], o_inside_res);
                end
                void'(pending_inside_q.pop_front());
                results_checked++;
            end
        end
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < PLANE_COUNT; i++)
            plane_model[i] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_zero_planes();
        test_unit_cube();
        test_unused_index();
        test_extreme_planes();
        test_backpressure();
        test_random_traffic();

        wait_drain();
        $display("covered: %0d words over sphere, box, point and undefined actions, %0d checked",
                 items_sent, results_checked);
        $display("planes: zero, unit cube, extremes, tilted boxes, raw random; %0d writes",
                 plane_writes);
        if (err_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
